// File: design/bole_pkg.sv
// Shared types for the bounded ordered list engine.
// Command codes and the control group broadcast to every list cell.
// No dependencies.
`timescale 1ns / 1ps

package bole_pkg;

    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_PREPEND    = 3'd1,
        CMD_READ       = 3'd2,
        CMD_INSERT_AT  = 3'd3,
        CMD_REMOVE_AT  = 3'd4,
        CMD_REMOVE_VAL = 3'd5
    } t_cmd;

    typedef struct packed {
        logic ins;      // open a gap at the index and store the word
        logic rem_at;   // close the gap at the index
        logic rem_val;  // match, then close the gap at the first hit
        logic pick;     // drive the entry at the index onto the read chain
    } t_bole_ctl;

endpackage

// File: design/bole_cell.sv
// One list cell: holds a single entry and shifts it to or from its neighbours.
// Carries the first-match and read-data chains along the row.
// Depends on bole_pkg.
`timescale 1ns / 1ps

module bole_cell
    import bole_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 5,
    parameter int WW  = 32
) (
    input  logic          i_clk,
    input  t_bole_ctl     i_ctl,
    input  logic [PW-1:0] i_at,
    input  logic [PW-1:0] i_count,
    input  logic [WW-1:0] i_word,
    input  logic [WW-1:0] i_left,
    input  logic [WW-1:0] i_right,
    input  logic          i_found,
    output logic          o_found,
    input  logic [WW-1:0] i_rd,
    output logic [WW-1:0] o_rd,
    output logic [WW-1:0] o_entry
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [WW-1:0] r_entry;
    logic [WW-1:0] n_entry;
    logic          w_used;
    logic          w_match;
    logic          w_pick;

    assign w_used  = MY_IDX < i_count;
    assign w_match = i_ctl.rem_val && w_used && (r_entry == i_word);
    assign o_found = i_found | w_match;
    assign w_pick  = (i_ctl.pick && w_used && (MY_IDX == i_at)) || (w_match && !i_found);
    assign o_rd    = i_rd | (w_pick ? r_entry : '0);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && (MY_IDX > i_at)) begin
            n_entry = i_left;
        end else if (i_ctl.ins && (MY_IDX == i_at)) begin
            n_entry = i_word;
        end else if ((i_ctl.rem_at && (MY_IDX >= i_at)) || (i_ctl.rem_val && o_found)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: design/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: command register, decode,
// the row of list cells and the result register. Depends on bole_pkg, bole_cell.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------------
//  in       | i_in_valid / o_in_stall     | i_command, i_position, i_data_word
//  out      | o_out_valid / i_out_stall   | o_status, o_read_word, o_entry_count
//
// An item is registered on acceptance and executed across all cells at once when
// the result register is free; its result is registered, so one item per cycle is
// sustained while the output is not stalled. The ripple of the first-match
// and read chains through DEPTH cells sets the execute path.
// Synchronous active-low reset empties the list; entries themselves are not cleared.
// A stalled result holds the executing item, which in turn stalls the input.
`timescale 1ns / 1ps

module bounded_ordered_list_engine
    import bole_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CMD_W-1:0]          i_command,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [DATA_W-1:0]  i_data_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_status,
    output logic signed [DATA_W-1:0]  o_read_word,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] FULL = PW'(DEPTH);

    logic                  r_cmd_valid;
    t_cmd                  r_cmd;
    logic [POS_W-1:0]      r_pos;
    logic [WORD_WIDTH-1:0] r_word;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic                  r_status;
    logic [DATA_W-1:0]     r_read;
    logic [COUNT_W-1:0]    r_count_out;

    logic                  w_fire;
    logic                  w_accept;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_cnt;
    logic [PW-1:0]         w_at;
    logic                  w_full;
    logic                  w_ok;
    logic                  w_done;
    t_bole_ctl             w_ctl;

    logic [WORD_WIDTH-1:0] w_entry [DEPTH];
    logic                  w_found [DEPTH+1];
    logic [WORD_WIDTH-1:0] w_rd    [DEPTH+1];

    assign w_fire     = r_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_cmd_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_pos  = PW'(r_pos);
    assign w_cnt  = PW'(r_count);
    assign w_full = (w_cnt == FULL);

    always_comb begin
        w_ctl   = '0;
        w_at    = w_pos;
        w_ok    = 1'b0;
        unique case (r_cmd)
            CMD_APPEND: begin
                w_at      = w_cnt;
                w_ok      = !w_full;
                w_ctl.ins = w_fire && w_ok;
            end
            CMD_PREPEND: begin
                w_at      = '0;
                w_ok      = !w_full;
                w_ctl.ins = w_fire && w_ok;
            end
            CMD_READ: begin
                w_ok       = (w_pos < w_cnt);
                w_ctl.pick = 1'b1;
            end
            CMD_INSERT_AT: begin
                w_ok      = !w_full && (w_pos <= w_cnt);
                w_ctl.ins = w_fire && w_ok;
            end
            CMD_REMOVE_AT: begin
                w_ok         = (w_pos < w_cnt);
                w_ctl.pick   = 1'b1;
                w_ctl.rem_at = w_fire && w_ok;
            end
            CMD_REMOVE_VAL: begin
                w_ctl.rem_val = w_fire;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign w_done = (r_cmd == CMD_REMOVE_VAL) ? w_found[DEPTH] : w_ok;

    always_comb begin
        n_count = r_count;
        if (w_done && (r_cmd == CMD_APPEND || r_cmd == CMD_PREPEND || r_cmd == CMD_INSERT_AT)) begin
            n_count = r_count + CW'(1);
        end else if (w_done && (r_cmd == CMD_REMOVE_AT || r_cmd == CMD_REMOVE_VAL)) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_found[0] = 1'b0;
    assign w_rd[0]    = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_left;
        logic [WORD_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = r_word;
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        bole_cell #(
            .IDX (g),
            .PW  (PW),
            .WW  (WORD_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_at    (w_at),
            .i_count (w_cnt),
            .i_word  (r_word),
            .i_left  (w_left),
            .i_right (w_right),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .i_rd    (w_rd[g]),
            .o_rd    (w_rd[g+1]),
            .o_entry (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cmd_valid <= 1'b1;
            end else if (w_fire) begin
                r_cmd_valid <= 1'b0;
            end
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= t_cmd'(i_command);
            r_pos  <= i_position;
            r_word <= WORD_WIDTH'(i_data_word);
        end
        if (w_fire) begin
            r_status    <= !w_done;
            r_read      <= w_done ? DATA_W'(w_rd[DEPTH]) : '0;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_word   = r_read;
    assign o_entry_count = r_count_out;

endmodule

// File: test/tb.sv
// Testbench for bounded_ordered_list_engine: directed and random list commands,
// each result checked against an in-bench ordered list predictor.
// Depends on bole_pkg and the bounded_ordered_list_engine RTL.
`timescale 1ns / 1ps

module tb
    import bole_pkg::*;
();

    localparam int DEPTH       = 16;
    localparam int N_RANDOM    = 1700;
    localparam int QUIET_ITEMS = 150;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam logic             ST_OK        = 1'b0;
    localparam logic             ST_FAIL      = 1'b1;

    localparam logic signed [DATA_W-1:0] W_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] W_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] W_ONES = -32'sd1;

    typedef struct {
        logic signed [DATA_W-1:0] word [DEPTH];
        int                       n;
    } t_list;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] word;
        bit                       hold;
    } t_list_cmd;

    typedef struct {
        logic                     status;
        logic signed [DATA_W-1:0] rd;
        logic [COUNT_W-1:0]       count;
    } t_list_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [CMD_W-1:0]          i_command = '0;
    logic [POS_W-1:0]          i_position = '0;
    logic signed [DATA_W-1:0]  i_data_word = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic                      o_status;
    logic signed [DATA_W-1:0]  o_read_word;
    logic [COUNT_W-1:0]        o_entry_count;

    t_list_cmd    cmd_queue [$];
    t_list_result due_results [$];
    t_list        plan_list;
    t_list        model_list;
    t_list_cmd    on_bus;
    int           n_total = 0;
    int           n_accepted = 0;
    int           n_fail = 0;
    int           in_gap = 0;
    int           out_gap = 0;

    bounded_ordered_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_position    (i_position),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_word   (o_read_word),
        .o_entry_count (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_list_result list_apply(inout t_list l, input t_list_cmd c);
        t_list_result r;
        int           at;
        int           hit;
        int           i;
        r.status = ST_FAIL;
        r.rd     = '0;
        hit      = -1;
        case (c.cmd)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT: begin
                at = (c.cmd == CMD_APPEND) ? l.n : (c.cmd == CMD_PREPEND) ? 0 : int'(c.pos);
                if (l.n < DEPTH && at <= l.n) begin
                    for (i = l.n; i > at; i--)
                        l.word[i] = l.word[i-1];
                    l.word[at] = c.word;
                    l.n++;
                    r.status = ST_OK;
                end
            end
            CMD_READ: begin
                if (int'(c.pos) < l.n) begin
                    r.rd     = l.word[c.pos];
                    r.status = ST_OK;
                end
            end
            CMD_REMOVE_AT, CMD_REMOVE_VAL: begin
                if (c.cmd == CMD_REMOVE_AT) begin
                    if (int'(c.pos) < l.n)
                        hit = int'(c.pos);
                end else begin
                    for (i = l.n - 1; i >= 0; i--)
                        if (l.word[i] == c.word)
                            hit = i;
                end
                if (hit >= 0) begin
                    r.rd = l.word[hit];
                    for (i = hit; i < l.n - 1; i++)
                        l.word[i] = l.word[i+1];
                    l.n--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.count = l.n[COUNT_W-1:0];
        return r;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic signed [DATA_W-1:0] w, input bit hold);
        t_list_cmd it;
        it.cmd  = c;
        it.pos  = p;
        it.word = w;
        it.hold = hold;
        void'(list_apply(plan_list, it));
        cmd_queue.push_back(it);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word(input int keep);
        int roll;
        roll = $urandom_range(0, 99);
        if (plan_list.n > 0 && roll < keep)
            return plan_list.word[$urandom_range(0, plan_list.n - 1)];
        if (roll < keep + 15) begin
            case ($urandom_range(0, 3))
                0: return W_MIN;
                1: return W_MAX;
                2: return W_ONES;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int               k;
        int               mode;
        int               grow;
        int               lim;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        plan_list.n  = 0;
        model_list.n = 0;

        queue_cmd(CMD_REMOVE_VAL, 0, '0, 0);
        queue_cmd(CMD_READ, 0, '0, 0);
        queue_cmd(CMD_REMOVE_AT, 0, '0, 0);
        queue_cmd(CMD_INSERT_AT, 1, W_ONES, 0);
        queue_cmd(CMD_APPEND, 31, W_MIN, 0);
        queue_cmd(CMD_REMOVE_AT, 0, '0, 0);
        queue_cmd(CMD_INSERT_AT, 0, W_MAX, 0);
        queue_cmd(CMD_PREPEND, 0, W_ONES, 0);
        queue_cmd(CMD_INSERT_AT, 2, '0, 0);
        queue_cmd(CMD_INSERT_AT, 1, 32'sh5A5A_5A5A, 0);
        queue_cmd(CMD_READ, 0, '0, 0);
        queue_cmd(CMD_READ, 3, '0, 0);
        queue_cmd(CMD_READ, 4, '0, 0);
        queue_cmd(CMD_READ, 31, W_ONES, 0);
        queue_cmd(CMD_REMOVE_AT, 4, '0, 0);
        queue_cmd(CMD_INSERT_AT, 6, W_MIN, 0);
        queue_cmd(CMD_REMOVE_VAL, 0, 32'sh1234_5678, 0);
        queue_cmd(CMD_APPEND, 0, W_ONES, 0);
        queue_cmd(CMD_REMOVE_VAL, 0, W_ONES, 1);
        queue_cmd(CMD_READ, 3, '0, 0);
        queue_cmd(CMD_SPARE_LO, 0, '0, 0);
        queue_cmd(CMD_SPARE_HI, 31, W_ONES, 0);
        queue_cmd(CMD_REMOVE_VAL, 0, W_MAX, 0);
        queue_cmd(CMD_REMOVE_AT, 0, '0, 0);

        mode = 0;
        for (k = 0; k < N_RANDOM; k++) begin
            if (k > 0 && k % 64 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: grow = 70;
                1: grow = 20;
                default: grow = 45;
            endcase
            if ($urandom_range(0, 99) < 8) begin
                queue_cmd(CMD_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 31)),
                          $urandom, 0);
            end else begin
                if ($urandom_range(0, 99) < grow) begin
                    case ($urandom_range(0, 2))
                        0: c = CMD_APPEND;
                        1: c = CMD_PREPEND;
                        default: c = CMD_INSERT_AT;
                    endcase
                    lim = plan_list.n;
                end else begin
                    case ($urandom_range(0, 2))
                        0: c = CMD_READ;
                        1: c = CMD_REMOVE_AT;
                        default: c = CMD_REMOVE_VAL;
                    endcase
                    lim = (plan_list.n > 0) ? plan_list.n - 1 : 0;
                end
                if ($urandom_range(0, 9) == 0 || c == CMD_APPEND || c == CMD_PREPEND
                        || c == CMD_REMOVE_VAL)
                    p = POS_W'($urandom_range(0, 31));
                else
                    p = POS_W'($urandom_range(0, lim));
                queue_cmd(c, p, pick_word((c == CMD_REMOVE_VAL) ? 70 : 20),
                          (k % 400 == 200));
            end
        end
        n_total = cmd_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(posedge i_clk);
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // Driver: present one item at a time, hold it while stalled.
    always @(posedge i_clk) begin
        bit quiet;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            quiet = (n_accepted >= n_total - QUIET_ITEMS) || ((n_accepted / 128) % 3 == 0);
            if (i_in_valid && !o_in_stall) begin
                due_results.push_back(list_apply(model_list, on_bus));
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_queue.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (cmd_queue[0].hold && due_results.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 4) == 0) begin
                    in_gap = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else begin
                    on_bus = cmd_queue.pop_front();
                    i_in_valid  <= 1'b1;
                    i_command   <= on_bus.cmd;
                    i_position  <= on_bus.pos;
                    i_data_word <= on_bus.word;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        bit           quiet;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            quiet = (n_accepted >= n_total - QUIET_ITEMS) || ((n_accepted / 128) % 3 == 1);
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result with nothing expected");
                    n_fail++;
                end else begin
                    want = due_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        n_fail++;
                    end
                    if (o_read_word !== want.rd) begin
                        $error("read_word: expected %0d, got %0d", want.rd, o_read_word);
                        n_fail++;
                    end
                    if (o_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               o_entry_count);
                        n_fail++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_gap = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

endmodule
